FILE: sv/nset_pkg.sv
// Shared constants, codes, command and status types for the note state energy tracker.
package nset_pkg;

  localparam int NOTE_COUNT = 128;
  localparam int NOTE_W     = 7;
  localparam int IDX_W      = 8;
  localparam int VEL_W      = 7;
  localparam int CNT_W      = 8;
  localparam int VSUM_W     = 14;
  localparam int NSUM_W     = 13;

  // Divider sizes: dividend, divisor, quotient
  localparam int DVD_W = 41;
  localparam int DVS_W = 24;
  localparam int Q_W   = 17;

  // Operation codes
  localparam logic [1:0] OP_NOTE_ON  = 2'd0;
  localparam logic [1:0] OP_NOTE_OFF = 2'd1;
  localparam logic [1:0] OP_ALL_OFF  = 2'd2;
  localparam logic [1:0] OP_TICK     = 2'd3;

  // Register indexes
  localparam logic [1:0] REG_ENERGY_DECAY = 2'd0;
  localparam logic [1:0] REG_MEMORY_DECAY = 2'd1;
  localparam logic [1:0] REG_MEMORY_AMT   = 2'd2;
  localparam logic [1:0] REG_EVOLUTION    = 2'd3;

  localparam logic [15:0] ENERGY_DECAY_RST = 16'd63582;
  localparam logic [15:0] MEMORY_DECAY_RST = 16'd64153;

  // Fixed-point constants, 1.0 = 65536
  localparam logic [16:0] ONE_Q16     = 17'd65536;
  localparam logic [16:0] REG_DEFAULT = 17'd28086;    // (60-24)/84
  localparam logic [16:0] TDEN_K      = 17'd76200;
  localparam logic [21:0] LOW_BASE    = 22'd3801088;  // 58.0
  localparam logic [22:0] HIGH_BASE   = 23'd917504;   // 14.0
  localparam logic [24:0] BAND_TOTAL  = 25'd6553600;  // 100.0
  localparam logic [22:0] MID_FLOOR   = 23'd524288;   // 8.0

  typedef enum logic [2:0] {
    DSEL_TGT,
    DSEL_REG,
    DSEL_LOW,
    DSEL_MID,
    DSEL_HIGH
  } dsel_t;

  typedef struct packed {
    logic  apply;
    logic  scan_clr;
    logic  scan_en;
    logic  prep;
    logic  div_go;
    logic  div_take;
    dsel_t div_sel;
    logic  nrg1;
    logic  nrg2;
    logic  nrg3;
    logic  bnd1;
    logic  bnd2;
    logic  bnd3;
    logic  out_load;
  } cmd_t;

  typedef struct packed {
    logic is_tick;
    logic scan_done;
    logic div_done;
    logic out_free;
  } sts_t;

  // Note number modulo 12 by reciprocal multiply
  function automatic logic [3:0] mod12(input logic [NOTE_W-1:0] x);
    logic [12:0] p;
    logic [3:0]  q;
    logic [6:0]  r;
    p = 13'(x) * 13'd43;
    q = p[12:9];
    r = x - 7'(7'(q) * 7'd12);
    return r[3:0];
  endfunction

  // floor(circ*3*65536/11) for circular root distance 0..5
  function automatic logic [16:0] circ_nov(input logic [2:0] c);
    logic [16:0] v;
    case (c)
      3'd0:    v = 17'd0;
      3'd1:    v = 17'd17873;
      3'd2:    v = 17'd35746;
      3'd3:    v = 17'd53620;
      3'd4:    v = 17'd71493;
      3'd5:    v = 17'd89367;
      default: v = 17'd0;
    endcase
    return v;
  endfunction

endpackage

FILE: sv/nset_ram.sv
// Generic single-write, single-read RAM with registered read data.
module nset_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

FILE: sv/nset_div.sv
// Restoring divider, one quotient bit per cycle, quotient known to fit 17 bits.
module nset_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       go,
  input  logic [nset_pkg::DVD_W-1:0] dividend,
  input  logic [nset_pkg::DVS_W-1:0] divisor,
  output logic                       done,
  output logic [nset_pkg::Q_W-1:0]   quot
);

  logic [nset_pkg::DVS_W-1:0] rem_r;
  logic [nset_pkg::Q_W-1:0]   q_r;
  logic [4:0]                 cnt_r;
  logic                       busy_r;
  logic                       done_r;
  logic [nset_pkg::DVS_W:0]   trial;
  logic                       ge;
  logic [nset_pkg::DVS_W-1:0] rem_nxt;

  // Trial subtract of the next bit
  always_comb begin
    trial   = {rem_r, q_r[nset_pkg::Q_W-1]};
    ge      = trial >= {1'b0, divisor};
    rem_nxt = ge ? nset_pkg::DVS_W'(trial - {1'b0, divisor}) : trial[nset_pkg::DVS_W-1:0];
  end

  // Load, iterate, flag done
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (go) begin
        busy_r <= 1'b1;
        cnt_r  <= 5'(nset_pkg::Q_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 5'd1;
        if (cnt_r == 5'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      rem_r <= dividend[nset_pkg::DVD_W-1:nset_pkg::Q_W];
      q_r   <= dividend[nset_pkg::Q_W-1:0];
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      q_r   <= {q_r[nset_pkg::Q_W-2:0], ge};
    end
  end

  assign done = done_r;
  assign quot = q_r;

endmodule

FILE: sv/nset_dp.sv
// Datapath: note store, scan accumulators, followers, band shares and result register.
module nset_dp (
  input  logic                        clk,
  input  logic                        rst_n,
  input  nset_pkg::cmd_t              cmd,
  output nset_pkg::sts_t              sts,
  input  logic                        cfg_we,
  input  logic [1:0]                  cfg_index,
  input  logic [15:0]                 cfg_wdata,
  input  logic [1:0]                  in_operation,
  input  logic [6:0]                  in_note,
  input  logic [6:0]                  in_velocity,
  input  logic                        out_stall,
  output logic                        out_valid,
  output logic [7:0]                  out_active_notes,
  output logic [3:0]                  out_root_pitch_class,
  output logic [15:0]                 out_world_energy,
  output logic [15:0]                 out_memory_level,
  output logic [15:0]                 out_band_low,
  output logic [15:0]                 out_band_mid,
  output logic [15:0]                 out_band_high
);

  // Configuration registers
  logic [15:0] edecay_r, mdecay_r, mamt_r, evo_r;

  // Note store
  logic [nset_pkg::NOTE_COUNT-1:0] held_r;
  logic                            ram_we;
  logic [nset_pkg::NOTE_W-1:0]     ram_waddr;
  logic [nset_pkg::VEL_W-1:0]      ram_wdata;
  logic [nset_pkg::VEL_W-1:0]      ram_rdata;
  logic [1:0]                      op_eff;
  logic                            note_ok;

  // Scan
  logic [nset_pkg::IDX_W-1:0]  idx_r;
  logic                        rd_v_r;
  logic                        rd_held_r;
  logic [nset_pkg::NOTE_W-1:0] rd_idx_r;
  logic [nset_pkg::CNT_W-1:0]  count_r;
  logic [nset_pkg::VSUM_W-1:0] velsum_r;
  logic [nset_pkg::NSUM_W-1:0] notesum_r;
  logic [nset_pkg::NOTE_W-1:0] lowest_r;

  // Tick arithmetic
  logic [2:0]  m;
  logic [9:0]  mfac;
  logic [12:0] nlim;
  logic [23:0] tnum_r, tden_r;
  logic [13:0] rden_r;
  logic [12:0] rnum_r;
  logic        rzero_r, has_r;
  logic [3:0]  root_r, last_root_r;
  logic [15:0] target_r, energy_r, mem_r;
  logic        ege_r;
  logic [15:0] diff_r, nov_r;
  logic [31:0] dmp_r, eprod_r, nmp_r;
  logic [3:0]  rdist;
  logic [3:0]  dist_c;
  logic [2:0]  circ;
  logic [17:0] nov_sum;
  logic [16:0] reg_r;
  logic [21:0] low_r;
  logic [22:0] high_r, mid_r;
  logic [24:0] mid_s;
  logic [23:0] total_r;
  logic [15:0] sh_low_r, sh_mid_r, sh_high_r;
  logic [15:0] q_sat;

  // Divider hookup
  logic [nset_pkg::DVD_W-1:0] dvd;
  logic [nset_pkg::DVS_W-1:0] dvs;
  logic                       div_done;
  logic [nset_pkg::Q_W-1:0]   quot;
  logic                       out_valid_r;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      edecay_r <= nset_pkg::ENERGY_DECAY_RST;
      mdecay_r <= nset_pkg::MEMORY_DECAY_RST;
      mamt_r   <= '0;
      evo_r    <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        nset_pkg::REG_ENERGY_DECAY: edecay_r <= cfg_wdata;
        nset_pkg::REG_MEMORY_DECAY: mdecay_r <= cfg_wdata;
        nset_pkg::REG_MEMORY_AMT:   mamt_r   <= cfg_wdata;
        nset_pkg::REG_EVOLUTION:    evo_r    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Decode the request; zero velocity note on acts as note off
  always_comb begin
    op_eff = (in_operation == nset_pkg::OP_NOTE_ON && in_velocity == 7'd0)
             ? nset_pkg::OP_NOTE_OFF : in_operation;
    note_ok   = {1'b0, in_note} < nset_pkg::IDX_W'(nset_pkg::NOTE_COUNT);
    ram_we    = cmd.apply && note_ok &&
                (op_eff == nset_pkg::OP_NOTE_ON || op_eff == nset_pkg::OP_NOTE_OFF);
    ram_waddr = in_note;
    ram_wdata = (op_eff == nset_pkg::OP_NOTE_ON) ? in_velocity : '0;
  end

  // Update held map
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r <= '0;
    end else if (cmd.apply) begin
      case (op_eff)
        nset_pkg::OP_NOTE_ON:  if (note_ok) held_r[in_note] <= 1'b1;
        nset_pkg::OP_NOTE_OFF: if (note_ok) held_r[in_note] <= 1'b0;
        nset_pkg::OP_ALL_OFF:  held_r <= '0;
        default: ;
      endcase
    end
  end

  nset_ram #(
    .WIDTH(nset_pkg::VEL_W),
    .DEPTH(nset_pkg::NOTE_COUNT)
  ) u_vel_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(idx_r[nset_pkg::NOTE_W-1:0]),
    .rdata(ram_rdata)
  );

  // Advance the scan index, one note per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r  <= '0;
      rd_v_r <= 1'b0;
    end else if (cmd.scan_clr) begin
      idx_r  <= '0;
      rd_v_r <= 1'b0;
    end else begin
      rd_v_r <= 1'b0;
      if (cmd.scan_en && idx_r < nset_pkg::IDX_W'(nset_pkg::NOTE_COUNT)) begin
        idx_r  <= idx_r + 1'b1;
        rd_v_r <= 1'b1;
      end
    end
  end

  // Accumulate held notes as the velocity read returns
  always_ff @(posedge clk) begin
    rd_held_r <= held_r[idx_r[nset_pkg::NOTE_W-1:0]];
    rd_idx_r  <= idx_r[nset_pkg::NOTE_W-1:0];
    if (cmd.scan_clr) begin
      count_r   <= '0;
      velsum_r  <= '0;
      notesum_r <= '0;
      lowest_r  <= '0;
    end else if (rd_v_r && rd_held_r) begin
      count_r   <= count_r + 1'b1;
      velsum_r  <= velsum_r + nset_pkg::VSUM_W'(ram_rdata);
      notesum_r <= notesum_r + nset_pkg::NSUM_W'(rd_idx_r);
      if (count_r == '0) lowest_r <= rd_idx_r;
    end
  end

  // Prepare divider operands and the root
  always_comb begin
    m    = (count_r < 8'd6) ? count_r[2:0] : 3'd6;
    mfac = 10'd270 + 10'(10'(m) * 10'd55);
    nlim = 13'(count_r) * 13'd24;
  end

  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      tnum_r  <= 24'(24'(velsum_r) * 24'(mfac));
      tden_r  <= 24'(24'(count_r) * 24'(nset_pkg::TDEN_K));
      rden_r  <= 14'(14'(count_r) * 14'd84);
      rzero_r <= notesum_r <= nlim;
      rnum_r  <= notesum_r - nlim;
      has_r   <= count_r != '0;
      root_r  <= (count_r != '0) ? nset_pkg::mod12(lowest_r) : last_root_r;
    end
  end

  // Select divider operands
  always_comb begin
    case (cmd.div_sel)
      nset_pkg::DSEL_TGT: begin
        dvd = {1'b0, tnum_r, 16'b0};
        dvs = tden_r;
      end
      nset_pkg::DSEL_REG: begin
        dvd = {12'b0, rnum_r, 16'b0};
        dvs = {10'b0, rden_r};
      end
      nset_pkg::DSEL_LOW: begin
        dvd = {3'b0, low_r, 16'b0};
        dvs = total_r;
      end
      nset_pkg::DSEL_MID: begin
        dvd = {2'b0, mid_r, 16'b0};
        dvs = total_r;
      end
      nset_pkg::DSEL_HIGH: begin
        dvd = {2'b0, high_r, 16'b0};
        dvs = total_r;
      end
      default: begin
        dvd = '0;
        dvs = total_r;
      end
    endcase
  end

  nset_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .go      (cmd.div_go),
    .dividend(dvd),
    .divisor (dvs),
    .done    (div_done),
    .quot    (quot)
  );

  assign q_sat = quot[16] ? 16'hFFFF : quot[15:0];

  // Novelty from circular root distance, and the unclamped mid band
  always_comb begin
    rdist   = (root_r > last_root_r) ? root_r - last_root_r : last_root_r - root_r;
    dist_c  = (rdist > 4'd11) ? 4'd11 : rdist;
    circ    = (dist_c < 4'd11 - dist_c) ? dist_c[2:0] : 3'(4'd11 - dist_c);
    nov_sum = 18'(nset_pkg::circ_nov(circ)) + 18'(target_r[15:2]);
    mid_s   = nset_pkg::BAND_TOTAL - 25'(low_r) - 25'(high_r);
  end

  // Capture quotients, step followers and bands
  always_ff @(posedge clk) begin
    if (cmd.div_take) begin
      case (cmd.div_sel)
        nset_pkg::DSEL_TGT:  target_r  <= has_r ? q_sat : 16'd0;
        nset_pkg::DSEL_REG:  reg_r     <= !has_r ? nset_pkg::REG_DEFAULT :
                                          rzero_r ? 17'd0 :
                                          (quot > nset_pkg::ONE_Q16) ? nset_pkg::ONE_Q16 : quot;
        nset_pkg::DSEL_LOW:  sh_low_r  <= q_sat;
        nset_pkg::DSEL_MID:  sh_mid_r  <= q_sat;
        nset_pkg::DSEL_HIGH: sh_high_r <= q_sat;
        default: ;
      endcase
    end
    if (cmd.nrg1) begin
      ege_r  <= energy_r >= target_r;
      diff_r <= (energy_r >= target_r) ? energy_r - target_r : target_r - energy_r;
      nov_r  <= (nov_sum > 18'd65535) ? 16'hFFFF : nov_sum[15:0];
      dmp_r  <= mem_r * mdecay_r;
    end
    if (cmd.nrg2) begin
      eprod_r <= diff_r * edecay_r;
      nmp_r   <= nov_r * mamt_r;
    end
    if (cmd.bnd1) begin
      low_r  <= nset_pkg::LOW_BASE - 22'(22'(reg_r) * 22'd42);
      high_r <= nset_pkg::HIGH_BASE + 23'(23'(reg_r) * 23'd30) + 23'(23'(evo_r) * 23'd24);
    end
    if (cmd.bnd2) begin
      mid_r <= ($signed(mid_s) < $signed({2'b0, nset_pkg::MID_FLOOR}))
               ? nset_pkg::MID_FLOOR : mid_s[22:0];
    end
    if (cmd.bnd3) begin
      total_r <= 24'(low_r) + 24'(mid_r) + 24'(high_r);
    end
  end

  // Update follower state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      energy_r    <= '0;
      mem_r       <= '0;
      last_root_r <= '0;
    end else if (cmd.nrg3) begin
      energy_r    <= ege_r ? target_r + eprod_r[31:16] : target_r - eprod_r[31:16];
      mem_r       <= (dmp_r[31:16] > nmp_r[31:16]) ? dmp_r[31:16] : nmp_r[31:16];
      last_root_r <= root_r;
    end
  end

  // Hold the result until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_active_notes     <= count_r;
      out_root_pitch_class <= root_r;
      out_world_energy     <= energy_r;
      out_memory_level     <= mem_r;
      out_band_low         <= sh_low_r;
      out_band_mid         <= sh_mid_r;
      out_band_high        <= sh_high_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign sts.is_tick   = in_operation == nset_pkg::OP_TICK;
  assign sts.scan_done = idx_r == nset_pkg::IDX_W'(nset_pkg::NOTE_COUNT) && !rd_v_r;
  assign sts.div_done  = div_done;
  assign sts.out_free  = !out_valid_r || !out_stall;

endmodule

FILE: sv/nset_ctrl.sv
// Controller: sequences the scan, divisions, follower and band steps of a tick.
module nset_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  nset_pkg::sts_t sts,
  output nset_pkg::cmd_t cmd,
  output logic           busy
);

  typedef enum logic [4:0] {
    S_IDLE, S_SCAN, S_PREP,
    S_TGT_GO, S_TGT_WAIT,
    S_NRG1, S_NRG2, S_NRG3,
    S_REG_GO, S_REG_WAIT,
    S_BND1, S_BND2, S_BND3,
    S_LOW_GO, S_LOW_WAIT,
    S_MID_GO, S_MID_WAIT,
    S_HIGH_GO, S_HIGH_WAIT,
    S_OUT
  } state_t;

  state_t state_r, state_nxt;

  // Decode commands and next state
  always_comb begin
    cmd       = '0;
    cmd.div_sel = nset_pkg::DSEL_TGT;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (sts.is_tick) begin
            cmd.scan_clr = 1'b1;
            state_nxt    = S_SCAN;
          end else begin
            cmd.apply = 1'b1;
          end
        end
      end
      S_SCAN: begin
        cmd.scan_en = 1'b1;
        if (sts.scan_done) state_nxt = S_PREP;
      end
      S_PREP: begin
        cmd.prep  = 1'b1;
        state_nxt = S_TGT_GO;
      end
      S_TGT_GO: begin
        cmd.div_go = 1'b1;
        state_nxt  = S_TGT_WAIT;
      end
      S_TGT_WAIT: begin
        cmd.div_take = sts.div_done;
        if (sts.div_done) state_nxt = S_NRG1;
      end
      S_NRG1: begin
        cmd.nrg1  = 1'b1;
        state_nxt = S_NRG2;
      end
      S_NRG2: begin
        cmd.nrg2  = 1'b1;
        state_nxt = S_NRG3;
      end
      S_NRG3: begin
        cmd.nrg3  = 1'b1;
        state_nxt = S_REG_GO;
      end
      S_REG_GO: begin
        cmd.div_sel = nset_pkg::DSEL_REG;
        cmd.div_go  = 1'b1;
        state_nxt   = S_REG_WAIT;
      end
      S_REG_WAIT: begin
        cmd.div_sel  = nset_pkg::DSEL_REG;
        cmd.div_take = sts.div_done;
        if (sts.div_done) state_nxt = S_BND1;
      end
      S_BND1: begin
        cmd.bnd1  = 1'b1;
        state_nxt = S_BND2;
      end
      S_BND2: begin
        cmd.bnd2  = 1'b1;
        state_nxt = S_BND3;
      end
      S_BND3: begin
        cmd.bnd3  = 1'b1;
        state_nxt = S_LOW_GO;
      end
      S_LOW_GO: begin
        cmd.div_sel = nset_pkg::DSEL_LOW;
        cmd.div_go  = 1'b1;
        state_nxt   = S_LOW_WAIT;
      end
      S_LOW_WAIT: begin
        cmd.div_sel  = nset_pkg::DSEL_LOW;
        cmd.div_take = sts.div_done;
        if (sts.div_done) state_nxt = S_MID_GO;
      end
      S_MID_GO: begin
        cmd.div_sel = nset_pkg::DSEL_MID;
        cmd.div_go  = 1'b1;
        state_nxt   = S_MID_WAIT;
      end
      S_MID_WAIT: begin
        cmd.div_sel  = nset_pkg::DSEL_MID;
        cmd.div_take = sts.div_done;
        if (sts.div_done) state_nxt = S_HIGH_GO;
      end
      S_HIGH_GO: begin
        cmd.div_sel = nset_pkg::DSEL_HIGH;
        cmd.div_go  = 1'b1;
        state_nxt   = S_HIGH_WAIT;
      end
      S_HIGH_WAIT: begin
        cmd.div_sel  = nset_pkg::DSEL_HIGH;
        cmd.div_take = sts.div_done;
        if (sts.div_done) state_nxt = S_OUT;
      end
      S_OUT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Hold state and the registered busy flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      busy    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      busy    <= state_nxt != S_IDLE;
    end
  end

endmodule

FILE: sv/note_state_energy_tracker.sv
// Top level of the note state energy tracker: controller, datapath, checks.
//
//  channel  direction  handshake            payload
//  in_      request    in_valid / in_stall  operation, note, velocity
//  out_     result     out_valid/out_stall  active_notes, root, energy, memory, bands
//  cfg_     write      cfg_we               cfg_index, cfg_wdata
//
// Note on, note off and all notes off are applied without raising in_stall.
// A tick holds in_stall after it is accepted until its result is loaded: a scan
// of 128 velocity RAM reads, five divider passes of 17 quotient bits each, and
// seven steps (prep, three follower steps, three band steps).
// Reset is synchronous; the held map clears at once, velocities need no clear.
// A result held under out_stall blocks only the final load of the next tick.
module note_state_energy_tracker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_operation,
  input  logic [6:0]  in_note,
  input  logic [6:0]  in_velocity,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_active_notes,
  output logic [3:0]  out_root_pitch_class,
  output logic [15:0] out_world_energy,
  output logic [15:0] out_memory_level,
  output logic [15:0] out_band_low,
  output logic [15:0] out_band_mid,
  output logic [15:0] out_band_high,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);

  nset_pkg::cmd_t cmd;
  nset_pkg::sts_t sts;
  logic           busy;

  nset_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .sts     (sts),
    .cmd     (cmd),
    .busy    (busy)
  );

  nset_dp u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .sts                 (sts),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata),
    .in_operation        (in_operation),
    .in_note             (in_note),
    .in_velocity         (in_velocity),
    .out_stall           (out_stall),
    .out_valid           (out_valid),
    .out_active_notes    (out_active_notes),
    .out_root_pitch_class(out_root_pitch_class),
    .out_world_energy    (out_world_energy),
    .out_memory_level    (out_memory_level),
    .out_band_low        (out_band_low),
    .out_band_mid        (out_band_mid),
    .out_band_high       (out_band_high)
  );

  assign in_stall = busy;

  // Note requests do not leave the block busy
  a_note_quick: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_operation != nset_pkg::OP_TICK) |=> !in_stall)
    else $error("note request left the block busy");

  // A tick starts the sequence
  a_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_operation == nset_pkg::OP_TICK) |=> in_stall)
    else $error("tick did not start the sequence");

  // Result fields stay in range
  a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_root_pitch_class <= 4'd11 && out_active_notes <= 8'd128))
    else $error("result field out of range");

endmodule
